// ----- rtl/rhc_pkg.sv -----
// Shared constants and types for the RGB to HSV pixel converter.
package rhc_pkg;

	// Default channel width of one color component
	localparam int CHANNEL_BITS_DEF = 8;

	// Hue is a 0.16 fraction of a full turn
	localparam int HUE_FRAC_BITS = 16;

	// Which channel holds the maximum; red wins ties over green, green over blue
	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

endpackage

// ----- rtl/rgb_to_hsv_convert.sv -----
// Throughput: one pixel per cycle while the output is not stalled; the depth
// comes from the 16 restoring division steps of the hue fraction, one quotient
// bit per pipeline stage, with the saturation quotient computed in parallel in
// the first CHANNEL_BITS of those stages.
// A stall at the output freezes every stage at once; nothing is dropped.
// Reset (arst_n, asynchronous, active low) clears the valid bits only.
module rgb_to_hsv_convert
	import rhc_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata fields from bit 0 up: red_in, green_in, blue_in, zero fill
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// m_tdata fields from bit 0 up: hue_out, sat_out, val_out, zero fill
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [((HUE_FRAC_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CB    = CHANNEL_BITS;
	localparam int NSTEP = HUE_FRAC_BITS;
	localparam int HW    = CB + 3;   // holds 6*delta and the hue remainder
	localparam int OW    = ((NSTEP + 2 * CB + 7) / 8) * 8;

	// Global advance: every stage moves when the output slot is free or taken
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Input fields
	logic [CB-1:0] red_in, green_in, blue_in;
	assign red_in   = s_tdata[0 +: CB];
	assign green_in = s_tdata[CB +: CB];
	assign blue_in  = s_tdata[2 * CB +: CB];

	// Find the maximum channel by priority and the minimum
	max_sel_t      sel_in;
	logic [CB-1:0] mx_in, mn_in;
	always_comb begin
		if (red_in >= green_in && red_in >= blue_in) begin
			sel_in = SEL_RED;
			mx_in  = red_in;
		end else if (green_in >= blue_in) begin
			sel_in = SEL_GREEN;
			mx_in  = green_in;
		end else begin
			sel_in = SEL_BLUE;
			mx_in  = blue_in;
		end
		mn_in = red_in;
		if (green_in < mn_in) mn_in = green_in;
		if (blue_in < mn_in) mn_in = blue_in;
	end

	// Stage registers ahead of the division
	max_sel_t      sel_s1, sel_s2;
	logic [CB-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [CB-1:0] d_s2, p_s2, m_s2, mx_s2, mx_s3;
	logic [HW:0]   n_s3;
	logic [HW-1:0] d6_s3;
	logic [2*CB-1:0] sa_s3;
	logic          gray_s3;
	logic          vld_s1, vld_s2, vld_s3;

	// Division stages; index 0 is stage 4, index i holds the state after i steps
	logic [HW-1:0]    hrem_sd [0:NSTEP];
	logic [HW-1:0]    d6_sd   [0:NSTEP];
	logic [NSTEP-1:0] hq_sd   [0:NSTEP];
	logic [CB-1:0]    srem_sd [0:NSTEP];
	logic [CB-1:0]    slo_sd  [0:NSTEP];
	logic [CB-1:0]    sq_sd   [0:NSTEP];
	logic [CB-1:0]    mx_sd   [0:NSTEP];
	logic             gray_sd [0:NSTEP];
	logic             vld_sd  [0:NSTEP];

	// Stage 3 operands: base of 6, 8 or 10 times delta
	logic [HW:0] dw_s2, base6_s2, base_s2;
	always_comb begin
		dw_s2    = {4'b0000, d_s2};
		base6_s2 = (dw_s2 << 2) + (dw_s2 << 1);
		case (sel_s2)
			SEL_RED:   base_s2 = base6_s2;
			SEL_GREEN: base_s2 = dw_s2 << 3;
			SEL_BLUE:  base_s2 = (dw_s2 << 3) + (dw_s2 << 1);
			default:   base_s2 = base6_s2;
		endcase
	end

	// Hue remainder after the integer step, offset by one full turn
	logic [HW-1:0] hrem0_s3;
	always_comb begin
		if (n_s3 >= {1'b0, d6_s3}) begin
			hrem0_s3 = HW'(n_s3 - {1'b0, d6_s3});
		end else begin
			hrem0_s3 = n_s3[HW-1:0];
		end
	end

	// Advance the front stages (payload)
	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= sel_in;
			r_s1   <= red_in;
			g_s1   <= green_in;
			b_s1   <= blue_in;
			mx_s1  <= mx_in;
			mn_s1  <= mn_in;

			d_s2   <= mx_s1 - mn_s1;
			sel_s2 <= sel_s1;
			mx_s2  <= mx_s1;
			case (sel_s1)
				SEL_RED: begin
					p_s2 <= g_s1;
					m_s2 <= b_s1;
				end
				SEL_GREEN: begin
					p_s2 <= b_s1;
					m_s2 <= r_s1;
				end
				default: begin
					p_s2 <= r_s1;
					m_s2 <= g_s1;
				end
			endcase

			n_s3    <= base_s2 + {4'b0000, p_s2} - {4'b0000, m_s2};
			d6_s3   <= base6_s2[HW-1:0];
			sa_s3   <= {d_s2, {CB{1'b0}}} - {{CB{1'b0}}, d_s2};
			gray_s3 <= (d_s2 == '0);
			mx_s3   <= mx_s2;

			hrem_sd[0] <= hrem0_s3;
			d6_sd[0]   <= d6_s3;
			hq_sd[0]   <= '0;
			srem_sd[0] <= sa_s3[2*CB-1:CB];
			slo_sd[0]  <= sa_s3[CB-1:0];
			sq_sd[0]   <= '0;
			mx_sd[0]   <= mx_s3;
			gray_sd[0] <= gray_s3;
		end
	end

	// One restoring division step per stage for hue, and for saturation early on
	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		logic [HW:0]   htrial;
		logic          hbit;
		logic [HW-1:0] hnext;
		logic [CB-1:0] snext, slo_next, sq_next;

		assign htrial = {hrem_sd[i], 1'b0};
		assign hbit   = (htrial >= {1'b0, d6_sd[i]});
		assign hnext  = hbit ? HW'(htrial - {1'b0, d6_sd[i]}) : htrial[HW-1:0];

		if (i < CB) begin : g_sat
			logic [CB:0] strial;
			logic        sbit;
			assign strial   = {srem_sd[i], slo_sd[i][CB-1]};
			assign sbit     = (strial >= {1'b0, mx_sd[i]});
			assign snext    = sbit ? CB'(strial - {1'b0, mx_sd[i]}) : strial[CB-1:0];
			assign slo_next = {slo_sd[i][CB-2:0], 1'b0};
			assign sq_next  = {sq_sd[i][CB-2:0], sbit};
		end else begin : g_hold
			assign snext    = srem_sd[i];
			assign slo_next = slo_sd[i];
			assign sq_next  = sq_sd[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hrem_sd[i+1] <= hnext;
				d6_sd[i+1]   <= d6_sd[i];
				hq_sd[i+1]   <= {hq_sd[i][NSTEP-2:0], hbit};
				srem_sd[i+1] <= snext;
				slo_sd[i+1]  <= slo_next;
				sq_sd[i+1]   <= sq_next;
				mx_sd[i+1]   <= mx_sd[i];
				gray_sd[i+1] <= gray_sd[i];
			end
		end
	end

	// Round to nearest, ties upward; gray pixels give zero hue and saturation
	logic             hround, sround;
	logic [NSTEP-1:0] hue_fin;
	logic [CB-1:0]    sat_fin;
	logic [OW-1:0]    word_fin;
	always_comb begin
		hround  = ({hrem_sd[NSTEP], 1'b0} >= {1'b0, d6_sd[NSTEP]});
		sround  = ({srem_sd[NSTEP], 1'b0} >= {1'b0, mx_sd[NSTEP]});
		hue_fin = hq_sd[NSTEP] + {{(NSTEP-1){1'b0}}, hround};
		sat_fin = sq_sd[NSTEP] + {{(CB-1){1'b0}}, sround};
		if (gray_sd[NSTEP]) begin
			hue_fin = '0;
			sat_fin = '0;
		end
		word_fin                     = '0;
		word_fin[0 +: NSTEP]         = hue_fin;
		word_fin[NSTEP +: CB]        = sat_fin;
		word_fin[NSTEP + CB +: CB]   = mx_sd[NSTEP];
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= word_fin;
		end
	end

	// Shift the valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			for (int j = 0; j <= NSTEP; j++) vld_sd[j] <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s1     <= s_tvalid;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_sd[0]  <= vld_s3;
			for (int j = 1; j <= NSTEP; j++) vld_sd[j] <= vld_sd[j-1];
			m_tvalid   <= vld_sd[NSTEP];
		end
	end

	// Gray pixels leave with zero hue and saturation
	a_gray_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_sd[NSTEP] && gray_sd[NSTEP]
		|=> m_tdata[0 +: NSTEP] == '0 && m_tdata[NSTEP +: CB] == '0)
		else $error("gray pixel with nonzero hue or saturation");

	// Hue remainder stays below 6*delta through the last step
	a_hrem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sd[NSTEP] && !gray_sd[NSTEP] |-> hrem_sd[NSTEP] < d6_sd[NSTEP])
		else $error("hue remainder out of range");

	// Saturation remainder stays below the maximum channel
	a_srem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sd[NSTEP] && !gray_sd[NSTEP] |-> srem_sd[NSTEP] < mx_sd[NSTEP])
		else $error("saturation remainder out of range");

	// A stall freezes the valid bits of stage 1, stage 3 and the last division stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s3) && $stable(vld_sd[NSTEP]))
		else $error("pipeline moved during a stall");

endmodule

// ----- sim/rhc_hsv_checker.sv -----
// Stream monitor and HSV predictor/scoreboard for the RGB to HSV converter.
module rhc_hsv_checker
	import rhc_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	// s_tdata fields from bit 0 up: red_in, green_in, blue_in, zero fill
	input  logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	// m_tdata fields from bit 0 up: hue_out, sat_out, val_out, zero fill
	input  logic [((HUE_FRAC_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output int   n_fail,
	output int   n_checked,
	output int   n_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned FULL_SCALE = (64'd1 << CHANNEL_BITS) - 64'd1;
	localparam longint unsigned HUE_TURN = 64'd1 << HUE_FRAC_BITS;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [HUE_FRAC_BITS-1:0] hue;
		logic [CHANNEL_BITS-1:0]  sat;
		logic [CHANNEL_BITS-1:0]  val;
	} hsv_t;

	typedef struct {
		logic [CHANNEL_BITS-1:0] r;
		logic [CHANNEL_BITS-1:0] g;
		logic [CHANNEL_BITS-1:0] b;
		hsv_t                    hsv;
	} hsv_expect_t;

	hsv_expect_t expected_hsv[$];

	// Exact integer HSV: value is the max, hue/sat are rounded quotients
	function automatic hsv_t predict_hsv(input longint unsigned r, input longint unsigned g,
			input longint unsigned b);
		hsv_t              res;
		longint unsigned   mx;
		longint unsigned   mn;
		longint unsigned   delta;
		longint unsigned   den;
		longint unsigned   num;
		max_sel_t          top_ch;

		mx = r;
		mn = r;
		top_ch = SEL_RED;
		// strict compares give red priority over green, green over blue
		if (g > mx) begin
			mx = g;
			top_ch = SEL_GREEN;
		end
		if (b > mx) begin
			mx = b;
			top_ch = SEL_BLUE;
		end
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;

		res.hue = '0;
		res.sat = '0;
		res.val = mx[CHANNEL_BITS-1:0];
		if (delta != 0) begin
			den = 6 * delta;
			// one full turn of offset keeps the numerator positive
			case (top_ch)
				SEL_RED:   num = den + g - b;
				SEL_GREEN: num = den + 2 * delta + b - r;
				default:   num = den + 4 * delta + r - g;
			endcase
			num = num * HUE_TURN;
			num = (2 * num + den) / (2 * den);
			res.hue = num[HUE_FRAC_BITS-1:0];
			num = (2 * FULL_SCALE * delta + mx) / (2 * mx);
			res.sat = num[CHANNEL_BITS-1:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want,
			input hsv_expect_t ctx);
		n_fail++;
		if (n_fail <= MAX_PRINTED)
			$display("[%0t] mismatch %s: got %0d, want %0d (rgb %0d %0d %0d)",
				$realtime, what, got, want, ctx.r, ctx.g, ctx.b);
	endtask

	// Check output beats against the oldest prediction, then queue new pixels
	always @(posedge clk) begin
		hsv_expect_t exp_px;
		hsv_expect_t in_px;
		hsv_t        got;

		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.hue = m_tdata[HUE_FRAC_BITS-1:0];
				got.sat = m_tdata[HUE_FRAC_BITS +: CHANNEL_BITS];
				got.val = m_tdata[HUE_FRAC_BITS + CHANNEL_BITS +: CHANNEL_BITS];
				if (expected_hsv.size() == 0) begin
					exp_px.r = '0;
					exp_px.g = '0;
					exp_px.b = '0;
					exp_px.hsv = '0;
					report_mismatch("unexpected beat, data", longint'(m_tdata),
						longint'(0), exp_px);
				end else begin
					exp_px = expected_hsv.pop_front();
					n_checked++;
					if (got.hue !== exp_px.hsv.hue)
						report_mismatch("hue", longint'(got.hue),
							longint'(exp_px.hsv.hue), exp_px);
					if (got.sat !== exp_px.hsv.sat)
						report_mismatch("sat", longint'(got.sat),
							longint'(exp_px.hsv.sat), exp_px);
					if (got.val !== exp_px.hsv.val)
						report_mismatch("val", longint'(got.val),
							longint'(exp_px.hsv.val), exp_px);
				end
			end
			if (s_tvalid && s_tready) begin
				in_px.r = s_tdata[0 +: CHANNEL_BITS];
				in_px.g = s_tdata[CHANNEL_BITS +: CHANNEL_BITS];
				in_px.b = s_tdata[2 * CHANNEL_BITS +: CHANNEL_BITS];
				in_px.hsv = predict_hsv(in_px.r, in_px.g, in_px.b);
				expected_hsv.insert(expected_hsv.size(), in_px);
			end
			n_pending = expected_hsv.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// Top-level testbench for the RGB to HSV converter: clock, reset, pixel stimulus, verdict.
module tb
	import rhc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = CHANNEL_BITS_DEF;
	localparam int IN_W = ((3 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((HUE_FRAC_BITS + 2 * CB + 7) / 8) * 8;
	localparam int N_RANDOM = 1100;
	localparam int N_CALM_TAIL = 150;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum {
		MIX_UNIFORM,
		MIX_GRAY,
		MIX_TIE,
		MIX_NEAR_GRAY,
		MIX_DIM,
		MIX_EXTREME
	} pixel_mix_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	int n_fail;
	int n_checked;
	int n_pending;
	int n_directed = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	always #6 clk = ~clk;

	rgb_to_hsv_convert u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rhc_hsv_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.n_fail    (n_fail),
		.n_checked (n_checked),
		.n_pending (n_pending)
	);

	// Output backpressure: random stall bursts of random length unless calm
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, n_pending);
			$display("rgb_to_hsv_convert regression: fail");
			$finish;
		end
	end

	// Present one pixel, optionally after an input gap, and hold until accepted
	task automatic send_pixel(input int unsigned r, input int unsigned g, input int unsigned b);
		int              gap;
		logic [IN_W-1:0] word;

		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[0 +: CB] = r[CB-1:0];
		word[CB +: CB] = g[CB-1:0];
		word[2 * CB +: CB] = b[CB-1:0];
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_directed(input int unsigned r, input int unsigned g, input int unsigned b);
		send_pixel(r, g, b);
		n_directed++;
	endtask

	initial begin
		pixel_mix_t  mix;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		int unsigned v;
		int unsigned lo;
		int unsigned pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: black, white, gray, primaries, secondaries, max ties
		send_directed(0, 0, 0);
		send_directed(255, 255, 255);
		send_directed(128, 128, 128);
		send_directed(255, 0, 0);
		send_directed(0, 255, 0);
		send_directed(0, 0, 255);
		send_directed(255, 255, 0);
		send_directed(0, 255, 255);
		send_directed(255, 0, 255);
		send_directed(200, 200, 10);
		send_directed(10, 200, 200);
		send_directed(200, 10, 200);
		// hue just short of a full turn, unit deltas, tiny maxima
		send_directed(255, 0, 1);
		send_directed(255, 254, 254);
		send_directed(254, 255, 255);
		send_directed(1, 0, 0);
		send_directed(0, 1, 0);
		send_directed(0, 0, 1);
		send_directed(1, 1, 0);
		send_directed(37, 37, 36);
		send_directed(100, 50, 200);
		send_directed(30, 200, 90);
		send_directed(255, 128, 0);

		// Random pixels, weighted toward grays, ties and small deltas
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - N_CALM_TAIL)
				calm = 1'b1;
			pick = $urandom_range(0, 7);
			mix = (pick > 5) ? MIX_UNIFORM : pixel_mix_t'(pick);
			r = $urandom_range(0, 255);
			g = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
			case (mix)
				MIX_GRAY: begin
					g = r;
					b = r;
				end
				MIX_TIE: begin
					v = $urandom_range(1, 255);
					lo = $urandom_range(0, v - 1);
					case ($urandom_range(0, 2))
						0: begin r = v; g = v; b = lo; end
						1: begin r = lo; g = v; b = v; end
						default: begin r = v; g = lo; b = v; end
					endcase
				end
				MIX_NEAR_GRAY: begin
					v = $urandom_range(0, 252);
					r = v + $urandom_range(0, 3);
					g = v + $urandom_range(0, 3);
					b = v + $urandom_range(0, 3);
				end
				MIX_DIM: begin
					r = $urandom_range(0, 7);
					g = $urandom_range(0, 7);
					b = $urandom_range(0, 7);
				end
				MIX_EXTREME: begin
					if ($urandom_range(0, 1) == 0) r = ($urandom_range(0, 1) == 0) ? 0 : 255;
					if ($urandom_range(0, 1) == 0) g = ($urandom_range(0, 1) == 0) ? 0 : 255;
					if ($urandom_range(0, 1) == 0) b = ($urandom_range(0, 1) == 0) ? 0 : 255;
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
		s_tvalid <= 1'b0;

		// Drain the pipeline, then allow a few extra cycles for stray beats
		do @(negedge clk); while (n_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d pixels (%0d directed, %0d random) with input gaps and output stalls",
			n_checked, n_directed, N_RANDOM);
		$display("mix covered grays, max ties, near-gray, dim and saturated pixels; %0d errors",
			n_fail);
		if (n_fail == 0 && n_pending == 0)
			$display("rgb_to_hsv_convert regression: pass");
		else
			$display("rgb_to_hsv_convert regression: fail");
		$finish;
	end

endmodule

// ----- rgb_to_hsv_convert.f -----
rtl/rhc_pkg.sv
rtl/rgb_to_hsv_convert.sv
sim/rhc_hsv_checker.sv
sim/tb.sv
